[sv/i2cmbe_pkg.sv]
`default_nettype none
package i2cmbe_pkg;

  localparam int DATA_BITS = 8;
  localparam int BIT_W     = $clog2(DATA_BITS);

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_SACK  = 3'd4,
    OP_RACK  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]           operation;
    logic [DATA_BITS-1:0] tx_byte;
    logic                 ack_level;
    logic [DATA_BITS-1:0] bus_sda_bits;
  } in_item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic [DATA_BITS-1:0] rx_data;
    logic                 ack_seen;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  function automatic logic op_is_valid(input logic [2:0] op);
    return (op == OP_START) || (op == OP_STOP) || (op == OP_WRITE) ||
           (op == OP_READ) || (op == OP_SACK) || (op == OP_RACK);
  endfunction

endpackage
`default_nettype wire

[sv/i2cmbe_ctrl.sv]
`default_nettype none
module i2cmbe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [2:0]         in_op,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire i2cmbe_pkg::stat_t  stat,
  output i2cmbe_pkg::cmd_t        cmd
);
  import i2cmbe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_EMIT);
  assign cmd.load    = in_valid && in_ready && op_is_valid(in_op);
  assign cmd.advance = out_valid && out_ready && !stat.last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready && stat.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/i2cmbe_dp.sv]
`default_nettype none
module i2cmbe_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire i2cmbe_pkg::in_item_t in_data,
  input  wire i2cmbe_pkg::cmd_t     cmd,
  output i2cmbe_pkg::stat_t         stat,
  output i2cmbe_pkg::out_item_t     out_data
);
  import i2cmbe_pkg::*;

  logic [2:0]           op_r;
  logic                 ackl_r;
  logic [DATA_BITS-1:0] bus_r;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic [DATA_BITS-1:0] rx_r, rx_nxt;
  logic                 ack_r, ack_nxt;
  logic                 last_r, last_nxt;

  logic [2:0]           op_s;
  logic                 ackl_s;
  logic [DATA_BITS-1:0] bus_s;
  logic [DATA_BITS-1:0] shift_s;
  logic [1:0]           phase_s;
  logic [BIT_W-1:0]     bit_s;
  logic                 bit_end;

  // a new command starts from the input item, otherwise from the held one
  assign op_s    = cmd.load ? in_data.operation    : op_r;
  assign ackl_s  = cmd.load ? in_data.ack_level    : ackl_r;
  assign bus_s   = cmd.load ? in_data.bus_sda_bits : bus_r;
  assign shift_s = cmd.load ? in_data.tx_byte      : shift_r;
  assign phase_s = cmd.load ? 2'd0                 : phase_r;
  assign bit_s   = cmd.load ? '0                   : bit_r;
  assign bit_end = (bit_s == BIT_W'(DATA_BITS - 1));

  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rx_nxt    = '0;
    ack_nxt   = 1'b0;
    last_nxt  = 1'b0;
    phase_nxt = phase_s + 2'd1;
    bit_nxt   = bit_s;
    shift_nxt = shift_s;
    unique case (op_s)
      OP_START: begin
        case (phase_s)
          2'd0:    sda_nxt = 1'b1;
          2'd1:    scl_nxt = 1'b1;
          2'd2:    sda_nxt = 1'b0;
          default: begin
            scl_nxt  = 1'b0;
            last_nxt = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (phase_s)
          2'd0:    sda_nxt = 1'b0;
          2'd1:    scl_nxt = 1'b1;
          default: begin
            sda_nxt  = 1'b1;
            last_nxt = 1'b1;
          end
        endcase
      end
      OP_WRITE: begin
        case (phase_s)
          2'd0:    sda_nxt = shift_s[DATA_BITS-1];
          2'd1:    scl_nxt = 1'b1;
          default: begin
            scl_nxt   = 1'b0;
            shift_nxt = {shift_s[DATA_BITS-2:0], 1'b0};
            phase_nxt = 2'd0;
            bit_nxt   = bit_s + BIT_W'(1);
            last_nxt  = bit_end;
          end
        endcase
      end
      OP_READ: begin
        case (phase_s)
          2'd0:    sda_nxt = 1'b1;
          2'd1:    scl_nxt = 1'b1;
          default: begin
            scl_nxt   = 1'b0;
            phase_nxt = 2'd1;
            bit_nxt   = bit_s + BIT_W'(1);
            last_nxt  = bit_end;
            // samples arrive msb first, so the assembled byte is the bus byte
            rx_nxt    = bit_end ? bus_s : '0;
          end
        endcase
      end
      OP_SACK: begin
        case (phase_s)
          2'd0:    sda_nxt = ackl_s;
          2'd1:    scl_nxt = 1'b1;
          default: begin
            scl_nxt  = 1'b0;
            last_nxt = 1'b1;
          end
        endcase
      end
      OP_RACK: begin
        case (phase_s)
          2'd0:    sda_nxt = 1'b1;
          2'd1:    scl_nxt = 1'b1;
          default: begin
            scl_nxt  = 1'b0;
            ack_nxt  = bus_s[DATA_BITS-1];
            last_nxt = 1'b1;
          end
        endcase
      end
      default: last_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r <= 1'b1;
      sda_r <= 1'b1;
    end else if (cmd.load || cmd.advance) begin
      scl_r <= scl_nxt;
      sda_r <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.advance) begin
      op_r    <= op_s;
      ackl_r  <= ackl_s;
      bus_r   <= bus_s;
      shift_r <= shift_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      rx_r    <= rx_nxt;
      ack_r   <= ack_nxt;
      last_r  <= last_nxt;
    end
  end

  assign stat.last          = last_r;
  assign out_data.scl_level = scl_r;
  assign out_data.sda_level = sda_r;
  assign out_data.rx_data   = rx_r;
  assign out_data.ack_seen  = ack_r;
  assign out_data.last      = last_r;

endmodule
`default_nettype wire

[sv/i2c_master_bit_engine.sv]
// first pin event is offered in the cycle after the command transaction
// one event per cycle while out_ready stays high
// unused operation codes are taken and give no events
// reset drives scl and sda released high and leaves the engine idle
`default_nettype none
module i2c_master_bit_engine (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire i2cmbe_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output i2cmbe_pkg::out_item_t      out_data
);
  import i2cmbe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  i2cmbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2cmbe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while events pending");

  a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("accepted command gave no event");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=> out_valid)
    else $error("command ended without last event");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> in_ready)
    else $error("engine not idle after last event");

endmodule
`default_nettype wire
